// ===== src/llf_pkg.sv =====
// Shared types, constants and the step program of the four-pole ladder filter.
package llf_pkg;

  // Default widths of the audio sample and of the filter state.
  localparam int LLF_SAMPLE_BITS = 24;
  localparam int LLF_STATE_BITS  = 32;

  // Working word of the shared arithmetic (signed, two's complement).
  localparam int LLF_WORD  = 64;
  // Multiplier digit taken per cycle.
  localparam int LLF_DIGIT = 16;

  // Configuration register widths and indexes.
  localparam int LLF_CUT_W  = 16;
  localparam int LLF_RES_W  = 16;
  localparam int LLF_RATE_W = 18;
  localparam int LLF_RESP_W = 2;
  localparam int LLF_IDX_W  = 2;
  localparam int LLF_CFG_W  = 18;

  localparam logic [LLF_IDX_W-1:0] REG_CUTOFF      = 2'd0;
  localparam logic [LLF_IDX_W-1:0] REG_RESONANCE   = 2'd1;
  localparam logic [LLF_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;
  localparam logic [LLF_IDX_W-1:0] REG_RESPONSE    = 2'd3;

  // Response codes; the spare code behaves as lowpass.
  localparam logic [LLF_RESP_W-1:0] RESP_LOW  = 2'd0;
  localparam logic [LLF_RESP_W-1:0] RESP_HIGH = 2'd1;
  localparam logic [LLF_RESP_W-1:0] RESP_BAND = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [LLF_CUT_W-1:0]  CUTOFF_RST = 16'd32768;
  localparam logic [LLF_RES_W-1:0]  RES_RST    = 16'd0;
  localparam logic [LLF_RATE_W-1:0] RATE_RST   = 18'd44100;

  // Twice the top frequency in hertz, and the lowest usable sample rate.
  localparam int TOP2_W = 14;
  localparam logic [TOP2_W-1:0]     TOP2_HZ  = 14'd8372;
  localparam logic [LLF_RATE_W-1:0] MIN_RATE = 18'd16000;

  // Program counter.
  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PROG_LAST = 6'd39;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_SHR1,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_K08,
    SRC_K56,
    SRC_K16,
    SRC_RES,
    SRC_RAW,
    SRC_FS,
    SRC_Q0,
    SRC_P,
    SRC_C,
    SRC_POLY,
    SRC_K,
    SRC_T,
    SRC_U,
    SRC_T1,
    SRC_V,
    SRC_X,
    SRC_FB,
    SRC_S0,
    SRC_S1,
    SRC_S2,
    SRC_S3
  } src_t;

  typedef enum logic [3:0] {
    DST_FS,
    DST_Q0,
    DST_P,
    DST_C,
    DST_POLY,
    DST_K,
    DST_T,
    DST_U,
    DST_T1,
    DST_V,
    DST_X,
    DST_S0,
    DST_S1,
    DST_S2,
    DST_S3
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t d;
    logic sat;
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } seq_state_t;

  // Step program: coefficients first, then the input feedback, the four
  // one-pole stages and the soft clip of the last stage.
  function automatic step_t prog_step(input logic [PC_W-1:0] pc);
    step_t s;
    unique case (pc)
      6'd0:  s = '{OP_DIV,  SRC_ZERO, SRC_ZERO, DST_FS,   1'b0};
      6'd1:  s = '{OP_SUB,  SRC_ONE,  SRC_FS,   DST_Q0,   1'b0};
      6'd2:  s = '{OP_MUL,  SRC_K08,  SRC_FS,   DST_T,    1'b0};
      6'd3:  s = '{OP_MUL,  SRC_T,    SRC_Q0,   DST_T,    1'b0};
      6'd4:  s = '{OP_ADD,  SRC_FS,   SRC_T,    DST_P,    1'b0};
      6'd5:  s = '{OP_ADD,  SRC_P,    SRC_P,    DST_C,    1'b0};
      6'd6:  s = '{OP_SUB,  SRC_C,    SRC_ONE,  DST_C,    1'b0};
      6'd7:  s = '{OP_MUL,  SRC_Q0,   SRC_Q0,   DST_T,    1'b0};
      6'd8:  s = '{OP_MUL,  SRC_K56,  SRC_T,    DST_T,    1'b0};
      6'd9:  s = '{OP_SUB,  SRC_ONE,  SRC_Q0,   DST_POLY, 1'b0};
      6'd10: s = '{OP_ADD,  SRC_POLY, SRC_T,    DST_POLY, 1'b0};
      6'd11: s = '{OP_MUL,  SRC_Q0,   SRC_POLY, DST_T,    1'b0};
      6'd12: s = '{OP_SHR1, SRC_T,    SRC_ZERO, DST_T,    1'b0};
      6'd13: s = '{OP_ADD,  SRC_ONE,  SRC_T,    DST_T,    1'b0};
      6'd14: s = '{OP_MUL,  SRC_RES,  SRC_T,    DST_K,    1'b0};
      6'd15: s = '{OP_MUL,  SRC_K,    SRC_S3,   DST_T,    1'b0};
      6'd16: s = '{OP_SUB,  SRC_RAW,  SRC_T,    DST_X,    1'b1};
      6'd17: s = '{OP_ADD,  SRC_X,    SRC_FB,   DST_T,    1'b0};
      6'd18: s = '{OP_MUL,  SRC_T,    SRC_P,    DST_T,    1'b0};
      6'd19: s = '{OP_MUL,  SRC_S0,   SRC_C,    DST_U,    1'b0};
      6'd20: s = '{OP_ADD,  SRC_S0,   SRC_ZERO, DST_T1,   1'b0};
      6'd21: s = '{OP_SUB,  SRC_T,    SRC_U,    DST_S0,   1'b1};
      6'd22: s = '{OP_ADD,  SRC_S0,   SRC_T1,   DST_T,    1'b0};
      6'd23: s = '{OP_MUL,  SRC_T,    SRC_P,    DST_T,    1'b0};
      6'd24: s = '{OP_MUL,  SRC_S1,   SRC_C,    DST_U,    1'b0};
      6'd25: s = '{OP_ADD,  SRC_S1,   SRC_ZERO, DST_T1,   1'b0};
      6'd26: s = '{OP_SUB,  SRC_T,    SRC_U,    DST_S1,   1'b1};
      6'd27: s = '{OP_ADD,  SRC_S1,   SRC_T1,   DST_T,    1'b0};
      6'd28: s = '{OP_MUL,  SRC_T,    SRC_P,    DST_T,    1'b0};
      6'd29: s = '{OP_MUL,  SRC_S2,   SRC_C,    DST_U,    1'b0};
      6'd30: s = '{OP_ADD,  SRC_S2,   SRC_ZERO, DST_T1,   1'b0};
      6'd31: s = '{OP_SUB,  SRC_T,    SRC_U,    DST_S2,   1'b1};
      6'd32: s = '{OP_ADD,  SRC_S2,   SRC_T1,   DST_T,    1'b0};
      6'd33: s = '{OP_MUL,  SRC_T,    SRC_P,    DST_T,    1'b0};
      6'd34: s = '{OP_MUL,  SRC_S3,   SRC_C,    DST_U,    1'b0};
      6'd35: s = '{OP_SUB,  SRC_T,    SRC_U,    DST_V,    1'b1};
      6'd36: s = '{OP_MUL,  SRC_V,    SRC_V,    DST_T,    1'b0};
      6'd37: s = '{OP_MUL,  SRC_T,    SRC_K16,  DST_T,    1'b0};
      6'd38: s = '{OP_MUL,  SRC_T,    SRC_V,    DST_T,    1'b0};
      6'd39: s = '{OP_SUB,  SRC_V,    SRC_T,    DST_S3,   1'b1};
      default: s = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T,  1'b0};
    endcase
    return s;
  endfunction

endpackage

// ===== src/llf_mul.sv =====
// Digit-serial fixed-point multiplier: floor(a*b / 2^FRAC_BITS), clipped to the word.
module llf_mul
  import llf_pkg::*;
#(
  parameter int FRAC_BITS = LLF_STATE_BITS - 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [LLF_WORD-1:0] a,
  input  logic signed [LLF_WORD-1:0] b,
  output logic                       done,
  output logic signed [LLF_WORD-1:0] res
);

  localparam int DIGITS = LLF_WORD / LLF_DIGIT;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int PW     = 2 * LLF_WORD;
  localparam int SW     = LLF_WORD + LLF_DIGIT;
  localparam int QW     = PW - FRAC_BITS + 1;
  localparam logic [QW-1:0] LIM_NEG = QW'({1'b1, {(LLF_WORD-1){1'b0}}});
  localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(LLF_WORD-1){1'b1}}});

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                neg_r;
  logic [LLF_WORD-1:0] ua_r;
  logic [LLF_WORD-1:0] ub_r;
  logic [PW-1:0]       acc_r;
  logic                done_r;
  logic [LLF_WORD-1:0] res_r;

  logic [SW-1:0]       sum;
  logic [QW-1:0]       qq;
  logic                rem_nz;
  logic [LLF_WORD-1:0] res_nxt;

  // One digit of b times all of a, added into the upper half of the product.
  always_comb begin
    sum = SW'(acc_r[PW-1:LLF_WORD]) + SW'(ua_r) * SW'(ub_r[LLF_DIGIT-1:0]);
  end

  // Scale down, round toward minus infinity and clip to the word.
  always_comb begin
    rem_nz = |acc_r[FRAC_BITS-1:0];
    qq     = QW'(acc_r[PW-1:FRAC_BITS]) + QW'(neg_r & rem_nz);
    if (neg_r) begin
      if (qq > LIM_NEG) begin
        res_nxt = LIM_NEG[LLF_WORD-1:0];
      end else begin
        res_nxt = '0 - qq[LLF_WORD-1:0];
      end
    end else begin
      if (qq > LIM_POS) begin
        res_nxt = LIM_POS[LLF_WORD-1:0];
      end else begin
        res_nxt = qq[LLF_WORD-1:0];
      end
    end
  end

  // Control of the digit loop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIGITS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // Operand magnitudes, partial product and result.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[LLF_WORD-1] ^ b[LLF_WORD-1];
      ua_r  <= a[LLF_WORD-1] ? ('0 - a) : a;
      ub_r  <= b[LLF_WORD-1] ? ('0 - b) : b;
      acc_r <= '0;
    end else if (busy_r && cnt_r != CNT_W'(DIGITS)) begin
      acc_r <= {sum, acc_r[LLF_WORD-1:LLF_DIGIT]};
      ub_r  <= ub_r >> LLF_DIGIT;
    end else if (busy_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== src/llf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module llf_div
  import llf_pkg::*;
#(
  parameter int NUM_W = LLF_STATE_BITS + 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [LLF_RATE_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [NUM_W-1:0]      num_r;
  logic [LLF_RATE_W-1:0] rem_r;
  logic [LLF_RATE_W-1:0] den_r;
  logic [LLF_RATE_W+1:0] diff;
  logic                  borrow;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    diff   = {1'b0, rem_r, num_r[NUM_W-1]} - {2'b00, den_r};
    borrow = diff[LLF_RATE_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NUM_W)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r && cnt_r != CNT_W'(NUM_W)) begin
      num_r <= {num_r[NUM_W-2:0], ~borrow};
      if (!borrow) begin
        rem_r <= diff[LLF_RATE_W-1:0];
      end else begin
        rem_r <= {rem_r[LLF_RATE_W-2:0], num_r[NUM_W-1]};
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== src/four_pole_ladder_filter.sv =====
// Top level of the resonant four-pole ladder filter with its step sequencer.
//
// Usage: one audio sample enters per beat on the in_ channel (valid/ready) and
// one filtered sample leaves per beat on the out_ channel (valid/ready).
// in_ready is high only while no sample is in work. The work of a sample goes
// to one digit-serial multiplier (18 products), a bit-serial divider for the
// cutoff scaling and 21 add, subtract and halve steps, all run in order by
// the step sequencer. Coefficients are derived again for every sample.
// The result sits in an output register; a new sample is taken while it waits,
// and the sequencer only stalls at the very end if the receiver still holds
// off the previous result.
// The user must write the configuration registers (cfg_we, cfg_index, cfg_data)
// only while the block is idle; the block does not enforce this. Reset clears
// the ladder stages, the fed-back input and out_valid, and loads register defaults.
module four_pole_ladder_filter
  import llf_pkg::*;
#(
  parameter int SAMPLE_BITS = LLF_SAMPLE_BITS,
  parameter int STATE_BITS  = LLF_STATE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-2:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_we,
  input  logic [LLF_IDX_W-1:0]          cfg_index,
  input  logic [LLF_CFG_W-1:0]          cfg_data
);

  localparam int FR    = STATE_BITS - 4;
  localparam int NUM_W = FR + 14;
  localparam int D_IN  = STATE_BITS - SAMPLE_BITS - 2;
  localparam int D_OUT = STATE_BITS - SAMPLE_BITS;
  localparam int YW    = STATE_BITS + SAMPLE_BITS + 4;

  localparam logic [LLF_WORD-1:0] ONE = 64'd1 << FR;
  localparam logic [LLF_WORD-1:0] K08 = (((64'd4 << (FR + 1)) / 64'd5) + 64'd1) >> 1;
  localparam logic [LLF_WORD-1:0] K56 = (((64'd28 << (FR + 1)) / 64'd5) + 64'd1) >> 1;
  localparam logic [LLF_WORD-1:0] K16 =
    (((64'd166667 << (FR + 1)) / 64'd1000000) + 64'd1) >> 1;

  localparam logic signed [LLF_WORD:0] ST_HI = (65'sd1 <<< (STATE_BITS - 1)) - 65'sd1;
  localparam logic signed [LLF_WORD:0] ST_LO = -ST_HI - 65'sd1;
  localparam logic signed [YW-1:0] OUT_HI =
    (YW'(1) <<< (SAMPLE_BITS - 1)) - YW'(1);
  localparam logic signed [YW-1:0] OUT_LO = -OUT_HI - YW'(1);

  // Configuration registers.
  logic [LLF_CUT_W-1:0]  cutoff_r;
  logic [LLF_RES_W-1:0]  resonance_r;
  logic [LLF_RATE_W-1:0] sample_rate_r;
  logic [LLF_RESP_W-1:0] response_r;

  // Sequencer.
  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  step_t           step;
  logic            mul_start, div_start, mul_done, div_done;
  logic            wr_en, out_load;
  logic signed [LLF_WORD-1:0] wr_val;

  // Working values.
  logic signed [LLF_WORD-1:0] raw_r, fs_r, q0_r, p_r, c_r, poly_r, k_r;
  logic signed [LLF_WORD-1:0] t_r, u_r, t1_r, v_r, x_r;
  logic signed [STATE_BITS-1:0] s0_r, s1_r, s2_r, s3_r, fb_r;

  logic signed [LLF_WORD-1:0] in_ext, raw_in;
  logic signed [LLF_WORD-1:0] a_val, b_val, alu_res, mul_res;
  logic signed [LLF_WORD:0]   alu_sum;
  logic [NUM_W-1:0]           div_quo, div_num;
  logic [LLF_RATE_W-1:0]      div_den;
  logic [TOP2_W+LLF_CUT_W-1:0] cut_scaled;

  logic signed [YW-1:0] y_diff, y_sel, y_shift;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r      <= CUTOFF_RST;
      resonance_r   <= RES_RST;
      sample_rate_r <= RATE_RST;
      response_r    <= RESP_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CUTOFF:      cutoff_r      <= cfg_data[LLF_CUT_W-1:0];
        REG_RESONANCE:   resonance_r   <= cfg_data[LLF_RES_W-1:0];
        REG_SAMPLE_RATE: sample_rate_r <= cfg_data;
        REG_RESPONSE:    response_r    <= cfg_data[LLF_RESP_W-1:0];
      endcase
    end
  end

  // Input sample brought to the state format.
  assign in_ext = LLF_WORD'(in_sample_in);
  generate
    if (D_IN >= 0) begin : g_in_up
      assign raw_in = in_ext <<< D_IN;
    end else begin : g_in_down
      assign raw_in = in_ext >>> (-D_IN);
    end
  endgenerate

  // Operand selection for the current step.
  function automatic logic signed [LLF_WORD-1:0] pick(input src_t s);
    logic signed [LLF_WORD-1:0] v;
    unique case (s)
      SRC_ZERO: v = '0;
      SRC_ONE:  v = ONE;
      SRC_K08:  v = K08;
      SRC_K56:  v = K56;
      SRC_K16:  v = K16;
      SRC_RES:  v = LLF_WORD'(resonance_r) << (FR - LLF_RES_W);
      SRC_RAW:  v = raw_r;
      SRC_FS:   v = fs_r;
      SRC_Q0:   v = q0_r;
      SRC_P:    v = p_r;
      SRC_C:    v = c_r;
      SRC_POLY: v = poly_r;
      SRC_K:    v = k_r;
      SRC_T:    v = t_r;
      SRC_U:    v = u_r;
      SRC_T1:   v = t1_r;
      SRC_V:    v = v_r;
      SRC_X:    v = x_r;
      SRC_FB:   v = LLF_WORD'(fb_r);
      SRC_S0:   v = LLF_WORD'(s0_r);
      SRC_S1:   v = LLF_WORD'(s1_r);
      SRC_S2:   v = LLF_WORD'(s2_r);
      SRC_S3:   v = LLF_WORD'(s3_r);
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign step = prog_step(pc_r);

  // The operands follow both the step and the registers that it reads.
  always_comb begin
    a_val = pick(step.a);
    b_val = pick(step.b);
  end

  // Add, subtract or halve, with optional clipping to the state range.
  always_comb begin
    if (step.op == OP_SUB) begin
      alu_sum = {a_val[LLF_WORD-1], a_val} - {b_val[LLF_WORD-1], b_val};
    end else begin
      alu_sum = {a_val[LLF_WORD-1], a_val} + {b_val[LLF_WORD-1], b_val};
    end
    if (step.op == OP_SHR1) begin
      alu_res = a_val >>> 1;
    end else if (step.sat && alu_sum > ST_HI) begin
      alu_res = ST_HI[LLF_WORD-1:0];
    end else if (step.sat && alu_sum < ST_LO) begin
      alu_res = ST_LO[LLF_WORD-1:0];
    end else begin
      alu_res = alu_sum[LLF_WORD-1:0];
    end
  end

  // Scaled cutoff over the clamped sample rate.
  assign cut_scaled = (TOP2_W + LLF_CUT_W)'(cutoff_r) * (TOP2_W + LLF_CUT_W)'(TOP2_HZ);
  assign div_num    = {cut_scaled, {(FR - LLF_CUT_W){1'b0}}};
  assign div_den    = (sample_rate_r < MIN_RATE) ? MIN_RATE : sample_rate_r;

  llf_mul #(.FRAC_BITS(FR)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (a_val),
    .b     (b_val),
    .done  (mul_done),
    .res   (mul_res)
  );

  llf_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer next state and step control.
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    wr_en     = 1'b0;
    wr_val    = alu_res;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ISSUE;
          pc_nxt    = '0;
        end
      end
      ST_ISSUE: begin
        if (step.op == OP_MUL) begin
          mul_start = 1'b1;
          state_nxt = ST_WAIT;
        end else if (step.op == OP_DIV) begin
          div_start = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          wr_en = 1'b1;
          if (pc_r == PROG_LAST) begin
            state_nxt = ST_OUT;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (mul_done || div_done) begin
          wr_en  = 1'b1;
          wr_val = (step.op == OP_DIV) ? LLF_WORD'(div_quo) : mul_res;
          if (pc_r == PROG_LAST) begin
            state_nxt = ST_OUT;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Coefficients and scratch values.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_r <= raw_in;
    end
    if (wr_en) begin
      case (step.d)
        DST_FS:   fs_r   <= wr_val;
        DST_Q0:   q0_r   <= wr_val;
        DST_P:    p_r    <= wr_val;
        DST_C:    c_r    <= wr_val;
        DST_POLY: poly_r <= wr_val;
        DST_K:    k_r    <= wr_val;
        DST_T:    t_r    <= wr_val;
        DST_U:    u_r    <= wr_val;
        DST_T1:   t1_r   <= wr_val;
        DST_V:    v_r    <= wr_val;
        DST_X:    x_r    <= wr_val;
        default: ;
      endcase
    end
  end

  // Ladder stages and fed-back input, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
      fb_r <= '0;
    end else begin
      if (wr_en) begin
        case (step.d)
          DST_S0:  s0_r <= wr_val[STATE_BITS-1:0];
          DST_S1:  s1_r <= wr_val[STATE_BITS-1:0];
          DST_S2:  s2_r <= wr_val[STATE_BITS-1:0];
          DST_S3:  s3_r <= wr_val[STATE_BITS-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        fb_r <= x_r[STATE_BITS-1:0];
      end
    end
  end

  // Response selection, scaling to the output format and clipping.
  always_comb begin
    y_diff = YW'(s2_r) - YW'(s3_r);
    if (response_r == RESP_HIGH) begin
      y_sel = YW'($signed(x_r[STATE_BITS-1:0])) - YW'(s3_r);
    end else if (response_r == RESP_BAND) begin
      y_sel = y_diff + (y_diff <<< 1);
    end else begin
      y_sel = YW'(s3_r);
    end
  end

  generate
    if (D_OUT >= 0) begin : g_out_down
      assign y_shift = y_sel >>> D_OUT;
    end else begin : g_out_up
      assign y_shift = y_sel <<< (-D_OUT);
    end
  endgenerate

  always_comb begin
    if (y_shift > OUT_HI) begin
      y_sat = OUT_HI[SAMPLE_BITS-1:0];
    end else if (y_shift < OUT_LO) begin
      y_sat = OUT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_shift[SAMPLE_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  // An accepted sample always starts the program from its first step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_ISSUE && pc_r == '0))
    else $error("accepted sample did not start the program");

  // The last step hands its result to a free output register and goes idle.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!out_valid_r || out_ready)) |=>
    (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into the output register");

  // The multiplier and the divider never finish in the same cycle.
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  // The fed-back input changes only when a result is delivered.
  a_fb_at_out: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(fb_r) |-> ($past(state_r) == ST_OUT))
    else $error("fed-back input changed outside the output step");

endmodule
